// ===== src/mlp_pkg.sv =====
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared types and constants for the localization pair matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mlp_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 16;

    localparam int POS_W   = 24;
    localparam int INT_W   = 24;
    localparam int FRAME_W = 20;
    localparam int TOL_W   = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // exact ellipsoid test widths
    localparam int DIFF_W = POS_W + 2;      // a - offset - b
    localparam int SQ_W   = 2 * TOL_W;      // m^2, e^2
    localparam int WGT_W  = 4 * TOL_W;      // product of two squared tolerances
    localparam int RHS_W  = 6 * TOL_W;      // product of all squared tolerances
    localparam int ACC_W  = RHS_W + 2;      // sum of three terms
    localparam int DIGIT_W    = 8;
    localparam int MAC_DIGITS = SQ_W / DIGIT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X    = 3'd0,
        REG_OFFSET_Y    = 3'd1,
        REG_OFFSET_Z    = 3'd2,
        REG_TOLERANCE_X = 3'd3,
        REG_TOLERANCE_Y = 3'd4,
        REG_TOLERANCE_Z = 3'd5,
        REG_THREE_DIMS  = 3'd6,
        REG_ORIENTATION = 3'd7
    } cfg_reg_t;

    // operand set of the shared multiply-accumulate unit
    typedef enum logic [2:0] {
        MS_W0,
        MS_W1,
        MS_W2,
        MS_R,
        MS_T
    } mac_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PSQ,
        ST_PMAC,
        ST_PST,
        ST_CHK,
        ST_READ,
        ST_DIFF,
        ST_DIR,
        ST_TSQ,
        ST_TMAC,
        ST_CMP,
        ST_PAIR,
        ST_FLUSH,
        ST_STORE
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     pre_start;
        logic     pre_sq;
        logic     pre_store;
        logic     mac_en;
        logic     acc_clr;
        mac_sel_t mac_sel;
        logic [1:0] dim;
        logic [2:0] digit;
        logic     dir;
        logic     sq_en;
        logic     rd_en;
        logic     diff_en;
        logic     cmp_en;
        logic     pair;
        logic     flush;
        logic     store;
    } cmd_t;

    typedef struct packed {
        logic       stale;
        logic       three_d;
        logic       have_entry;
        logic [1:0] fail;
        logic       match;
        logic       pend_valid;
        logic       out_free;
    } status_t;

    typedef struct packed {
        logic signed [POS_W-1:0] short_x;
        logic signed [POS_W-1:0] short_y;
        logic signed [POS_W-1:0] short_z;
        logic [INT_W-1:0]        short_intensity;
        logic signed [POS_W-1:0] long_x;
        logic signed [POS_W-1:0] long_y;
        logic signed [POS_W-1:0] long_z;
        logic [INT_W-1:0]        long_intensity;
    } pair_t;

endpackage

`default_nettype wire

// ===== src/mlp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlp_ctrl
// Sequencer: weight precompute after reset or configuration, then per item a walk over
// the buffered entries, two directions each, one tolerance term at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_ctrl #(
    parameter int BUFFER_DEPTH = mlp_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  mlp_pkg::status_t                     status,
    output mlp_pkg::cmd_t                        cmd,
    output logic [$clog2(BUFFER_DEPTH)-1:0]      rd_addr
);
    import mlp_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);

    state_t          state_reg, state_next;
    mac_sel_t        pre_sel_reg, pre_sel_next;
    logic [2:0]      digit_reg, digit_next;
    logic [1:0]      dim_reg, dim_next;
    logic            dir_reg, dir_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic            last_digit;
    logic [1:0]      last_dim;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pre_sel_reg <= MS_W0;
            digit_reg   <= '0;
            dim_reg     <= '0;
            dir_reg     <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            pre_sel_reg <= pre_sel_next;
            digit_reg   <= digit_next;
            dim_reg     <= dim_next;
            dir_reg     <= dir_next;
            idx_reg     <= idx_next;
        end
    end

    assign last_digit = (digit_reg == 3'(MAC_DIGITS - 1));
    assign last_dim   = status.three_d ? 2'd2 : 2'd1;
    assign rd_addr    = idx_reg;

    always_comb begin
        state_next   = state_reg;
        pre_sel_next = pre_sel_reg;
        digit_next   = digit_reg;
        dim_next     = dim_reg;
        dir_next     = dir_reg;
        idx_next     = idx_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.mac_sel  = pre_sel_reg;
        cmd.dim      = dim_reg;
        cmd.digit    = digit_reg;
        cmd.dir      = dir_reg;

        case (state_reg)
            ST_IDLE: begin
                if (status.stale) begin
                    cmd.pre_start = 1'b1;
                    state_next    = ST_PSQ;
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        cmd.accept = 1'b1;
                        idx_next   = '0;
                        state_next = ST_CHK;
                    end
                end
            end
            ST_PSQ: begin
                cmd.pre_sq   = 1'b1;
                pre_sel_next = MS_W0;
                digit_next   = '0;
                state_next   = ST_PMAC;
            end
            ST_PMAC: begin
                cmd.mac_en  = 1'b1;
                cmd.acc_clr = (digit_reg == '0);
                if (last_digit) begin
                    state_next = ST_PST;
                end else begin
                    digit_next = digit_reg + 3'd1;
                end
            end
            ST_PST: begin
                cmd.pre_store = 1'b1;
                digit_next    = '0;
                state_next    = ST_PMAC;
                case (pre_sel_reg)
                    MS_W0:   pre_sel_next = MS_W1;
                    MS_W1:   pre_sel_next = MS_W2;
                    MS_W2:   pre_sel_next = MS_R;
                    default: state_next   = ST_IDLE;
                endcase
            end
            ST_CHK: begin
                state_next = status.have_entry ? ST_READ : ST_FLUSH;
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff_en = 1'b1;
                dir_next    = 1'b0;
                state_next  = ST_DIR;
            end
            ST_DIR: begin
                // skip a direction that is out of range or already decided
                if (status.fail[dir_reg] || status.match) begin
                    if (dir_reg) begin
                        state_next = ST_PAIR;
                    end else begin
                        dir_next = 1'b1;
                    end
                end else begin
                    dim_next   = '0;
                    state_next = ST_TSQ;
                end
            end
            ST_TSQ: begin
                cmd.sq_en  = 1'b1;
                digit_next = '0;
                state_next = ST_TMAC;
            end
            ST_TMAC: begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = MS_T;
                cmd.acc_clr = (digit_reg == '0) && (dim_reg == '0);
                if (last_digit) begin
                    if (dim_reg == last_dim) begin
                        state_next = ST_CMP;
                    end else begin
                        dim_next   = dim_reg + 2'd1;
                        state_next = ST_TSQ;
                    end
                end else begin
                    digit_next = digit_reg + 3'd1;
                end
            end
            ST_CMP: begin
                cmd.cmp_en = 1'b1;
                if (dir_reg) begin
                    state_next = ST_PAIR;
                end else begin
                    dir_next   = 1'b1;
                    state_next = ST_DIR;
                end
            end
            ST_PAIR: begin
                if (!status.match) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CHK;
                end else if (!status.pend_valid || status.out_free) begin
                    cmd.pair   = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_FLUSH: begin
                if (!status.pend_valid) begin
                    state_next = ST_STORE;
                end else if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/mlp_dp.sv =====
// ----------------------------------------------------------------------------
// mlp_dp
// Datapath: configuration, entry buffer, difference and range check, shared
// 80x8 multiply-accumulate, pending pair and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_dp #(
    parameter int BUFFER_DEPTH = mlp_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [mlp_pkg::CFG_IDX_W-1:0]         cfg_wr_index,
    input  wire logic [mlp_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
    input  wire logic signed [mlp_pkg::POS_W-1:0]      s_pos_x,
    input  wire logic signed [mlp_pkg::POS_W-1:0]      s_pos_y,
    input  wire logic signed [mlp_pkg::POS_W-1:0]      s_pos_z,
    input  wire logic [mlp_pkg::INT_W-1:0]             s_intensity,
    input  wire logic [mlp_pkg::FRAME_W-1:0]           s_frame,
    input  mlp_pkg::cmd_t                              cmd,
    input  wire logic [$clog2(BUFFER_DEPTH)-1:0]       rd_addr,
    output mlp_pkg::status_t                           status,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output mlp_pkg::pair_t                             m_pair,
    output logic [mlp_pkg::FRAME_W-1:0]                m_pair_frame,
    output logic                                       m_last_of_run
);
    import mlp_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);

    // configuration
    logic signed [POS_W-1:0] off_reg [0:2];
    logic [TOL_W-1:0]        tol_reg [0:2];
    logic                    three_d_reg;
    logic [1:0]              orient_reg;
    logic                    stale_reg;

    // precomputed weights
    logic [SQ_W-1:0]  e2_reg [0:2];
    logic [WGT_W-1:0] w_reg  [0:2];
    logic [RHS_W-1:0] r_reg;

    // item and buffer
    logic signed [POS_W-1:0] b_x_reg, b_y_reg, b_z_reg;
    logic [INT_W-1:0]        b_int_reg;
    logic [FRAME_W-1:0]      cur_frame_reg;
    logic [IDX_W-1:0]        fill_reg;

    logic signed [POS_W-1:0] mem_x [0:BUFFER_DEPTH-1];
    logic signed [POS_W-1:0] mem_y [0:BUFFER_DEPTH-1];
    logic signed [POS_W-1:0] mem_z [0:BUFFER_DEPTH-1];
    logic [INT_W-1:0]        mem_int [0:BUFFER_DEPTH-1];
    logic signed [POS_W-1:0] rd_x_reg, rd_y_reg, rd_z_reg;
    logic [INT_W-1:0]        rd_int_reg;

    // test
    logic [TOL_W-1:0] mag_l_reg [0:2];
    logic [TOL_W-1:0] mag_r_reg [0:2];
    logic [1:0]       fail_reg;
    logic             match_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [ACC_W-1:0] acc_reg;

    // pairs
    pair_t pend_reg;
    logic  pend_valid_reg;
    pair_t out_reg;
    logic  out_valid_reg;
    logic  out_last_reg;
    logic [FRAME_W-1:0] out_frame_reg;

    logic [TOL_W-1:0]        e_eff [0:2];
    logic signed [POS_W-1:0] a_pos [0:2];
    logic signed [POS_W-1:0] b_pos [0:2];
    logic [DIFF_W-1:0]       abs_l [0:2];
    logic [DIFF_W-1:0]       abs_r [0:2];
    logic [1:0]              fail_next;
    logic [TOL_W-1:0]        mag_sel;
    logic [WGT_W-1:0]        a_op;
    logic [SQ_W-1:0]         b_op;
    logic [SQ_W-1:0]         b_shift;
    logic [DIGIT_W-1:0]      digit_val;
    logic [WGT_W+DIGIT_W-1:0] prod;
    logic [ACC_W-1:0]        prod_sh;
    logic                    short_new;
    pair_t                   pair_new;
    logic                    out_free;

    assign e_eff[0] = tol_reg[0];
    assign e_eff[1] = tol_reg[1];
    assign e_eff[2] = three_d_reg ? tol_reg[2] : TOL_W'(1);

    assign a_pos[0] = rd_x_reg;
    assign a_pos[1] = rd_y_reg;
    assign a_pos[2] = rd_z_reg;
    assign b_pos[0] = b_x_reg;
    assign b_pos[1] = b_y_reg;
    assign b_pos[2] = b_z_reg;

    // both orientations of the offset, magnitude and out-of-range check
    always_comb begin
        logic signed [DIFF_W-1:0] dl;
        logic signed [DIFF_W-1:0] dr;
        logic                     active;
        fail_next = 2'b00;
        for (int k = 0; k < 3; k++) begin
            dl = DIFF_W'(a_pos[k]) - DIFF_W'(off_reg[k]) - DIFF_W'(b_pos[k]);
            dr = DIFF_W'(b_pos[k]) - DIFF_W'(off_reg[k]) - DIFF_W'(a_pos[k]);
            abs_l[k] = dl[DIFF_W-1] ? DIFF_W'(-dl) : DIFF_W'(dl);
            abs_r[k] = dr[DIFF_W-1] ? DIFF_W'(-dr) : DIFF_W'(dr);
            active = (k < 2) || three_d_reg;
            if (active) begin
                if (e_eff[k] == '0 || abs_l[k] > DIFF_W'(e_eff[k])) fail_next[0] = 1'b1;
                if (e_eff[k] == '0 || abs_r[k] > DIFF_W'(e_eff[k])) fail_next[1] = 1'b1;
            end
        end
    end

    // operand selection for the shared unit
    always_comb begin
        mag_sel = '0;
        a_op    = '0;
        b_op    = '0;
        case (cmd.dim)
            2'd0:    mag_sel = cmd.dir ? mag_r_reg[0] : mag_l_reg[0];
            2'd1:    mag_sel = cmd.dir ? mag_r_reg[1] : mag_l_reg[1];
            2'd2:    mag_sel = cmd.dir ? mag_r_reg[2] : mag_l_reg[2];
            default: mag_sel = '0;
        endcase
        case (cmd.mac_sel)
            MS_W0: begin a_op = WGT_W'(e2_reg[1]); b_op = e2_reg[2]; end
            MS_W1: begin a_op = WGT_W'(e2_reg[0]); b_op = e2_reg[2]; end
            MS_W2: begin a_op = WGT_W'(e2_reg[0]); b_op = e2_reg[1]; end
            MS_R:  begin a_op = w_reg[0];          b_op = e2_reg[0]; end
            MS_T: begin
                b_op = sq_reg;
                case (cmd.dim)
                    2'd0:    a_op = w_reg[0];
                    2'd1:    a_op = w_reg[1];
                    2'd2:    a_op = w_reg[2];
                    default: a_op = '0;
                endcase
            end
            default: begin a_op = '0; b_op = '0; end
        endcase
    end

    assign b_shift   = b_op >> (cmd.digit * DIGIT_W);
    assign digit_val = b_shift[DIGIT_W-1:0];
    assign prod      = (WGT_W+DIGIT_W)'(a_op) * (WGT_W+DIGIT_W)'(digit_val);
    assign prod_sh   = ACC_W'(prod) << (cmd.digit * DIGIT_W);

    // short channel by orientation
    always_comb begin
        logic signed [POS_W-1:0] ac;
        logic signed [POS_W-1:0] bc;
        ac = orient_reg[0] ? rd_x_reg : rd_y_reg;
        bc = orient_reg[0] ? b_x_reg  : b_y_reg;
        short_new = orient_reg[1] ? !(ac < bc) : (ac < bc);
        if (short_new) begin
            pair_new.short_x         = b_x_reg;
            pair_new.short_y         = b_y_reg;
            pair_new.short_z         = three_d_reg ? b_z_reg : '0;
            pair_new.short_intensity = b_int_reg;
            pair_new.long_x          = rd_x_reg;
            pair_new.long_y          = rd_y_reg;
            pair_new.long_z          = three_d_reg ? rd_z_reg : '0;
            pair_new.long_intensity  = rd_int_reg;
        end else begin
            pair_new.short_x         = rd_x_reg;
            pair_new.short_y         = rd_y_reg;
            pair_new.short_z         = three_d_reg ? rd_z_reg : '0;
            pair_new.short_intensity = rd_int_reg;
            pair_new.long_x          = b_x_reg;
            pair_new.long_y          = b_y_reg;
            pair_new.long_z          = three_d_reg ? b_z_reg : '0;
            pair_new.long_intensity  = b_int_reg;
        end
    end

    assign out_free = !out_valid_reg || m_ready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg[0]     <= '0;
            off_reg[1]     <= '0;
            off_reg[2]     <= '0;
            tol_reg[0]     <= TOL_W'(1);
            tol_reg[1]     <= TOL_W'(1);
            tol_reg[2]     <= TOL_W'(1);
            three_d_reg    <= 1'b0;
            orient_reg     <= 2'd1;
            stale_reg      <= 1'b1;
            cur_frame_reg  <= '0;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            match_reg      <= 1'b0;
            fail_reg       <= 2'b00;
        end else begin
            if (cfg_wr_en) begin
                stale_reg <= 1'b1;
                case (cfg_reg_t'(cfg_wr_index))
                    REG_OFFSET_X:    off_reg[0]  <= cfg_wr_data;
                    REG_OFFSET_Y:    off_reg[1]  <= cfg_wr_data;
                    REG_OFFSET_Z:    off_reg[2]  <= cfg_wr_data;
                    REG_TOLERANCE_X: tol_reg[0]  <= cfg_wr_data[TOL_W-1:0];
                    REG_TOLERANCE_Y: tol_reg[1]  <= cfg_wr_data[TOL_W-1:0];
                    REG_TOLERANCE_Z: tol_reg[2]  <= cfg_wr_data[TOL_W-1:0];
                    REG_THREE_DIMS:  three_d_reg <= cfg_wr_data[0];
                    REG_ORIENTATION: orient_reg  <= cfg_wr_data[1:0];
                    default:         stale_reg   <= 1'b1;
                endcase
            end else if (cmd.pre_start) begin
                stale_reg <= 1'b0;
            end

            // new frame drops the buffer
            if (cmd.accept && s_frame != cur_frame_reg) begin
                cur_frame_reg <= s_frame;
                fill_reg      <= '0;
            end else if (cmd.store && fill_reg < IDX_W'(BUFFER_DEPTH - 1)) begin
                fill_reg <= fill_reg + 1'b1;
            end

            if (cmd.diff_en) begin
                fail_reg  <= fail_next;
                match_reg <= 1'b0;
            end else if (cmd.cmp_en && acc_reg <= ACC_W'(r_reg)) begin
                match_reg <= 1'b1;
            end

            if (cmd.pair) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end

            if ((cmd.pair && pend_valid_reg) || cmd.flush) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.pre_sq) begin
            for (int k = 0; k < 3; k++) begin
                e2_reg[k] <= SQ_W'(e_eff[k]) * SQ_W'(e_eff[k]);
            end
        end
        if (cmd.pre_store) begin
            case (cmd.mac_sel)
                MS_W0:   w_reg[0] <= acc_reg[WGT_W-1:0];
                MS_W1:   w_reg[1] <= acc_reg[WGT_W-1:0];
                MS_W2:   w_reg[2] <= acc_reg[WGT_W-1:0];
                default: r_reg    <= acc_reg[RHS_W-1:0];
            endcase
        end
        if (cmd.mac_en) begin
            acc_reg <= (cmd.acc_clr ? ACC_W'(0) : acc_reg) + prod_sh;
        end
        if (cmd.sq_en) begin
            sq_reg <= SQ_W'(mag_sel) * SQ_W'(mag_sel);
        end
        if (cmd.diff_en) begin
            for (int k = 0; k < 3; k++) begin
                mag_l_reg[k] <= abs_l[k][TOL_W-1:0];
                mag_r_reg[k] <= abs_r[k][TOL_W-1:0];
            end
        end
        if (cmd.accept) begin
            b_x_reg   <= s_pos_x;
            b_y_reg   <= s_pos_y;
            b_z_reg   <= s_pos_z;
            b_int_reg <= s_intensity;
        end
        if (cmd.store && fill_reg < IDX_W'(BUFFER_DEPTH - 1)) begin
            mem_x[fill_reg]   <= b_x_reg;
            mem_y[fill_reg]   <= b_y_reg;
            mem_z[fill_reg]   <= b_z_reg;
            mem_int[fill_reg] <= b_int_reg;
        end
        if (cmd.rd_en) begin
            rd_x_reg   <= mem_x[rd_addr];
            rd_y_reg   <= mem_y[rd_addr];
            rd_z_reg   <= mem_z[rd_addr];
            rd_int_reg <= mem_int[rd_addr];
        end
        if (cmd.pair) begin
            pend_reg <= pair_new;
        end
        // hold the frame with the pair, the next request may change it
        if ((cmd.pair && pend_valid_reg) || cmd.flush) begin
            out_reg       <= pend_reg;
            out_last_reg  <= cmd.flush;
            out_frame_reg <= cur_frame_reg;
        end
    end

    assign status.stale      = stale_reg;
    assign status.three_d    = three_d_reg;
    assign status.have_entry = rd_addr < fill_reg;
    assign status.fail       = fail_reg;
    assign status.match      = match_reg;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    assign m_valid       = out_valid_reg;
    assign m_pair        = out_reg;
    assign m_pair_frame  = out_frame_reg;
    assign m_last_of_run = out_last_reg;

endmodule

`default_nettype wire

// ===== src/match_localization_pairs.sv =====
// Per item: accept, then per buffered entry a read, a difference and range check and,
//   per direction tested, one squared term per dimension (D = 2 or 3) digit by digit
//   through the shared 80x8 multiply-accumulate and a compare; then final check, flush, store.
// Throughput: one item at a time; stalls on m_ready add cycles only when a pair waits.
// After reset or any configuration write, the weight precompute runs before the next
//   item is taken. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
// match_localization_pairs
// Pairs localizations of one frame whose offset-corrected distance lies inside
// the tolerance ellipsoid, tested exactly in integers.
// ----------------------------------------------------------------------------
`default_nettype none

module match_localization_pairs #(
    parameter int BUFFER_DEPTH = mlp_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mlp_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  wire logic [mlp_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [mlp_pkg::POS_W-1:0]    s_pos_x,
    input  wire logic signed [mlp_pkg::POS_W-1:0]    s_pos_y,
    input  wire logic signed [mlp_pkg::POS_W-1:0]    s_pos_z,
    input  wire logic [mlp_pkg::INT_W-1:0]           s_intensity,
    input  wire logic [mlp_pkg::FRAME_W-1:0]         s_frame,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [mlp_pkg::POS_W-1:0]         m_short_x,
    output logic signed [mlp_pkg::POS_W-1:0]         m_short_y,
    output logic signed [mlp_pkg::POS_W-1:0]         m_short_z,
    output logic [mlp_pkg::INT_W-1:0]                m_short_intensity,
    output logic signed [mlp_pkg::POS_W-1:0]         m_long_x,
    output logic signed [mlp_pkg::POS_W-1:0]         m_long_y,
    output logic signed [mlp_pkg::POS_W-1:0]         m_long_z,
    output logic [mlp_pkg::INT_W-1:0]                m_long_intensity,
    output logic [mlp_pkg::FRAME_W-1:0]              m_pair_frame,
    output logic                                     m_last_of_run
);
    import mlp_pkg::*;

    cmd_t                           cmd;
    status_t                        status;
    pair_t                          pair;
    logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr;

    mlp_ctrl #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    mlp_dp #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pos_z       (s_pos_z),
        .s_intensity   (s_intensity),
        .s_frame       (s_frame),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pair        (pair),
        .m_pair_frame  (m_pair_frame),
        .m_last_of_run (m_last_of_run)
    );

    assign m_short_x         = pair.short_x;
    assign m_short_y         = pair.short_y;
    assign m_short_z         = pair.short_z;
    assign m_short_intensity = pair.short_intensity;
    assign m_long_x          = pair.long_x;
    assign m_long_y          = pair.long_y;
    assign m_long_z          = pair.long_z;
    assign m_long_intensity  = pair.long_intensity;

`ifndef SYNTHESIS
    // one item at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous item still in work");

    // a configuration write forces a weight recompute before the next request
    a_cfg_recompute: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("request taken with stale weights");

    // no pair is left pending once the block is ready again
    a_pend_flushed: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !status.pend_valid)
        else $error("pending pair not flushed");
`endif

endmodule

`default_nettype wire

// ===== verif/match_localization_pairs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match_localization_pairs_checker
// Watches the configuration port, the request channel and the result channel,
// predicts the pairs of each accepted localization, and compares them with the
// produced pairs in order.
// ----------------------------------------------------------------------------
`default_nettype none

module match_localization_pairs_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [mlp_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  wire logic [mlp_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic signed [mlp_pkg::POS_W-1:0]    s_pos_x,
    input  wire logic signed [mlp_pkg::POS_W-1:0]    s_pos_y,
    input  wire logic signed [mlp_pkg::POS_W-1:0]    s_pos_z,
    input  wire logic [mlp_pkg::INT_W-1:0]           s_intensity,
    input  wire logic [mlp_pkg::FRAME_W-1:0]         s_frame,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic signed [mlp_pkg::POS_W-1:0]    m_short_x,
    input  wire logic signed [mlp_pkg::POS_W-1:0]    m_short_y,
    input  wire logic signed [mlp_pkg::POS_W-1:0]    m_short_z,
    input  wire logic [mlp_pkg::INT_W-1:0]           m_short_intensity,
    input  wire logic signed [mlp_pkg::POS_W-1:0]    m_long_x,
    input  wire logic signed [mlp_pkg::POS_W-1:0]    m_long_y,
    input  wire logic signed [mlp_pkg::POS_W-1:0]    m_long_z,
    input  wire logic [mlp_pkg::INT_W-1:0]           m_long_intensity,
    input  wire logic [mlp_pkg::FRAME_W-1:0]         m_pair_frame,
    input  wire logic                                m_last_of_run,
    output int                                       fail_count,
    output int                                       pending_count
);
    import mlp_pkg::*;

    localparam int DEPTH = DEFAULT_BUFFER_DEPTH;

    typedef struct {
        pair_t              pair;
        logic [FRAME_W-1:0] frame;
        logic               last;
    } pair_expect_t;

    pair_expect_t expected_pairs[$];

    logic signed [POS_W-1:0] offset[3];
    logic [TOL_W-1:0]        tol[3];
    logic                    three_d;
    logic [1:0]              orient;

    logic signed [POS_W-1:0] held_pos[DEPTH][3];
    logic [INT_W-1:0]        held_int[DEPTH];
    logic [FRAME_W-1:0]      frame_now;
    int                      held_count;

    function automatic bit in_ellipsoid(longint d0, longint d1, longint d2);
        longint       d[3];
        longint       mag[3];
        logic [127:0] e[3];
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] term;
        d = '{d0, d1, d2};
        for (int k = 0; k < 3; k++) begin
            if (k == 2 && !three_d) begin
                mag[k] = 0;
                e[k] = 1;
            end else begin
                mag[k] = (d[k] < 0) ? -d[k] : d[k];
                e[k] = tol[k];
            end
            if (e[k] == 0 || mag[k] > longint'(e[k]))
                return 1'b0;
        end
        lhs = 0;
        rhs = 1;
        for (int k = 0; k < 3; k++) begin
            term = 128'(mag[k]) * 128'(mag[k]);
            for (int j = 0; j < 3; j++)
                if (j != k)
                    term = term * e[j] * e[j];
            lhs = lhs + term;
            rhs = rhs * e[k] * e[k];
        end
        return lhs <= rhs;
    endfunction

    task automatic predict_pairs();
        logic signed [POS_W-1:0] nb[3];
        longint dl[3];
        longint dr[3];
        logic signed [POS_W-1:0] ac;
        logic signed [POS_W-1:0] bc;
        bit short_new;
        pair_expect_t pe;
        int first_new;
        nb = '{s_pos_x, s_pos_y, s_pos_z};
        if (s_frame != frame_now) begin
            held_count = 0;
            frame_now = s_frame;
        end
        first_new = expected_pairs.size();
        for (int i = 0; i < held_count; i++) begin
            for (int k = 0; k < 3; k++) begin
                dl[k] = longint'(held_pos[i][k]) - longint'(offset[k]) - longint'(nb[k]);
                dr[k] = longint'(nb[k]) - longint'(offset[k]) - longint'(held_pos[i][k]);
            end
            if (!in_ellipsoid(dl[0], dl[1], dl[2]) && !in_ellipsoid(dr[0], dr[1], dr[2]))
                continue;
            ac = orient[0] ? held_pos[i][0] : held_pos[i][1];
            bc = orient[0] ? nb[0] : nb[1];
            short_new = orient[1] ? !(ac < bc) : (ac < bc);
            pe.pair.short_x = short_new ? nb[0] : held_pos[i][0];
            pe.pair.short_y = short_new ? nb[1] : held_pos[i][1];
            pe.pair.short_z = !three_d ? '0 : short_new ? nb[2] : held_pos[i][2];
            pe.pair.short_intensity = short_new ? s_intensity : held_int[i];
            pe.pair.long_x = short_new ? held_pos[i][0] : nb[0];
            pe.pair.long_y = short_new ? held_pos[i][1] : nb[1];
            pe.pair.long_z = !three_d ? '0 : short_new ? held_pos[i][2] : nb[2];
            pe.pair.long_intensity = short_new ? held_int[i] : s_intensity;
            pe.frame = s_frame;
            pe.last = 1'b0;
            expected_pairs.insert(expected_pairs.size(), pe);
        end
        if (expected_pairs.size() > first_new)
            expected_pairs[expected_pairs.size()-1].last = 1'b1;
        if (held_count < DEPTH - 1) begin
            held_pos[held_count] = nb;
            held_int[held_count] = s_intensity;
            held_count++;
        end
    endtask

    task automatic check_field(string name, logic [POS_W-1:0] exp_v, logic [POS_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        pair_expect_t pe;
        if (!aresetn) begin
            offset = '{0, 0, 0};
            tol = '{1, 1, 1};
            three_d = 1'b0;
            orient = 2'd1;
            frame_now = '0;
            held_count = 0;
            expected_pairs.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_wr_index))
                    REG_OFFSET_X:    offset[0] = cfg_wr_data;
                    REG_OFFSET_Y:    offset[1] = cfg_wr_data;
                    REG_OFFSET_Z:    offset[2] = cfg_wr_data;
                    REG_TOLERANCE_X: tol[0] = cfg_wr_data[TOL_W-1:0];
                    REG_TOLERANCE_Y: tol[1] = cfg_wr_data[TOL_W-1:0];
                    REG_TOLERANCE_Z: tol[2] = cfg_wr_data[TOL_W-1:0];
                    REG_THREE_DIMS:  three_d = cfg_wr_data[0];
                    REG_ORIENTATION: orient = cfg_wr_data[1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_pairs.size() == 0) begin
                    $display("%0t: unexpected pair: expected none, actual short_x %h long_x %h",
                             $time, m_short_x, m_long_x);
                    fail_count++;
                end else begin
                    pe = expected_pairs.pop_front();
                    check_field("short_x", pe.pair.short_x, m_short_x);
                    check_field("short_y", pe.pair.short_y, m_short_y);
                    check_field("short_z", pe.pair.short_z, m_short_z);
                    check_field("short_intensity", pe.pair.short_intensity, m_short_intensity);
                    check_field("long_x", pe.pair.long_x, m_long_x);
                    check_field("long_y", pe.pair.long_y, m_long_y);
                    check_field("long_z", pe.pair.long_z, m_long_z);
                    check_field("long_intensity", pe.pair.long_intensity, m_long_intensity);
                    check_field("pair_frame", 24'(pe.frame), 24'(m_pair_frame));
                    check_field("last_of_run", 24'(pe.last), 24'(m_last_of_run));
                end
            end
            if (s_valid && s_ready)
                predict_pairs();
        end
        pending_count = expected_pairs.size();
    end

endmodule

`default_nettype wire

// ===== verif/match_localization_pairs_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match_localization_pairs_tb
// Drives directed and clustered random localizations through the pair matcher
// under several configurations and idle patterns; the checker predicts pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module match_localization_pairs_tb;
    import mlp_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int SETTLE_CYCLES = 1500;
    localparam int NUM_PHASES   = 8;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_wr_index;
    logic [CFG_DATA_W-1:0]   cfg_wr_data;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [POS_W-1:0] s_pos_x, s_pos_y, s_pos_z;
    logic [INT_W-1:0]        s_intensity;
    logic [FRAME_W-1:0]      s_frame;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [POS_W-1:0] m_short_x, m_short_y, m_short_z;
    logic [INT_W-1:0]        m_short_intensity;
    logic signed [POS_W-1:0] m_long_x, m_long_y, m_long_z;
    logic [INT_W-1:0]        m_long_intensity;
    logic [FRAME_W-1:0]      m_pair_frame;
    logic                    m_last_of_run;

    int fail_count;
    int pending_count;
    int cycle_count;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;

    // current settings, used to aim random items at the match ellipsoid
    int cur_off[3];
    int cur_tol[3];

    match_localization_pairs u_top (.*);

    match_localization_pairs_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** match_localization_pairs: FAILED **");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (3000) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
    endtask

    task automatic send_loc(int x, int y, int z, int inten, int fr);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= x[POS_W-1:0];
        s_pos_y <= y[POS_W-1:0];
        s_pos_z <= z[POS_W-1:0];
        s_intensity <= inten[INT_W-1:0];
        s_frame <= fr[FRAME_W-1:0];
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int frame_no;
        int base[3];
        int p[3];
        int group;
        int items;
        logic [CFG_DATA_W-1:0] regs[8];

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_pos_x = '0;
        s_pos_y = '0;
        s_pos_z = '0;
        s_intensity = '0;
        s_frame = '0;
        cycle_count = 0;
        tx_idle_pct = 25;
        rx_idle_pct = 74;
        hold_req = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part under reset settings: unit tolerance, no offset, 2D
        send_loc(0, 0, 0, 0, 0);
        send_loc(1, 0, 5, 24'hFFFFFF, 0);
        send_loc(0, -1, -8388608, 123, 0);
        send_loc(8388607, 8388607, 8388607, 24'hFFFFFF, 1048575);
        send_loc(8388607, 8388606, -8388608, 0, 1048575);
        send_loc(-8388608, -8388608, 8388607, 24'hAAAAAA, 1048575);
        // smaller frame number still starts a new frame
        send_loc(-8388608, -8388608, 0, 24'h555555, 3);
        send_loc(-8388607, -8388608, 0, 1, 3);
        // fill the buffer past its depth with items at the same x and y
        for (int i = 0; i < 17; i++)
            send_loc(100, -200, i, i, 7);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            tx_idle_pct = (ph < 3) ? 25 : (ph < 6) ? 74 : 0;
            rx_idle_pct = (ph < 3) ? 74 : (ph < 6) ? 25 : 0;
            for (int k = 0; k < 3; k++) begin
                cur_off[k] = $urandom_range(0, 1) ? $urandom_range(0, 5000) - 2500
                                                  : $urandom_range(0, 20) - 10;
                cur_tol[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1048575)
                                                         : $urandom_range(1, 3000);
            end
            regs[REG_THREE_DIMS] = $urandom_range(0, 1);
            regs[REG_ORIENTATION] = ph % 4;
            if (ph == 0) begin
                cur_off = '{8388607, -8388608, 8388607};
                cur_tol = '{1048575, 1048575, 1048575};
                regs[REG_THREE_DIMS] = 1;
            end else if (ph == 1) begin
                cur_off = '{-8388608, 8388607, -8388608};
                cur_tol = '{1, 1, 1};
            end else if (ph == 2) begin
                // zero tolerance on an active axis: nothing may match
                cur_tol[2] = 0;
                regs[REG_THREE_DIMS] = 1;
            end
            for (int k = 0; k < 3; k++) begin
                regs[REG_OFFSET_X + k] = cur_off[k][CFG_DATA_W-1:0];
                regs[REG_TOLERANCE_X + k] = cur_tol[k][CFG_DATA_W-1:0];
            end
            for (int r = 0; r < 8; r++)
                write_reg(cfg_reg_t'(r), regs[r]);
            cfg_wr_en <= 1'b0;
            @(negedge aclk);

            if (ph == 6)
                hold_req = 1'b1;
            frame_no = $urandom_range(0, 1000);
            items = 0;
            while (items < 46) begin
                // next frame: usually forward, sometimes a jump anywhere
                frame_no = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1048575)
                                                       : (frame_no + $urandom_range(0, 3));
                frame_no = frame_no & 20'hFFFFF;
                group = $urandom_range(1, 18);
                for (int k = 0; k < 3; k++)
                    base[k] = $urandom_range(0, 16777215) - 8388608;
                for (int g = 0; g < group; g++) begin
                    if ($urandom_range(0, 99) < 15) begin
                        send_loc($urandom, $urandom, $urandom, $urandom, frame_no);
                    end else begin
                        for (int k = 0; k < 3; k++) begin
                            p[k] = base[k] + $urandom_range(0, cur_tol[k]) - cur_tol[k] / 2;
                            if ($urandom_range(0, 1))
                                p[k] = p[k] + cur_off[k];
                        end
                        send_loc(p[0], p[1], p[2], $urandom, frame_no);
                    end
                    items++;
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("** match_localization_pairs: PASSED **");
        end else begin
            $display("** match_localization_pairs: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/mlp_pkg.sv
src/mlp_ctrl.sv
src/mlp_dp.sv
src/match_localization_pairs.sv
verif/match_localization_pairs_checker.sv
verif/match_localization_pairs_tb.sv
